// ----- design/log_record_parser_crc32_core_macros.svh -----
// Assertion helpers for the files that check their own logic; only the core includes them.
`ifndef LOG_RECORD_PARSER_CRC32_CORE_MACROS_SVH
`define LOG_RECORD_PARSER_CRC32_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LRP_ASSERT_IMPLY(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LRP_ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error(msg);

`endif

// ----- design/lrp_pkg.sv -----
package lrp_pkg;

   localparam int unsigned FifoDepth      = 4;
   localparam int unsigned FifoPtrWidth   = $clog2(FifoDepth);
   localparam int unsigned FifoCountWidth = $clog2(FifoDepth + 1);

   localparam int unsigned CsrIndexWidth = 1;
   localparam int unsigned CsrDataWidth  = 32;

   localparam logic [31:0] MagicReset   = 32'h57414C4B;
   localparam logic [15:0] VersionReset = 16'd1;
   localparam logic [31:0] CrcPoly      = 32'hEDB88320;
   localparam logic [31:0] CrcAllOnes   = 32'hFFFFFFFF;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_MAGIC_WORD     = 1'b0,
      CSR_FORMAT_VERSION = 1'b1
   } csr_index_type;

   typedef enum logic [3:0] {
      PH_MAGIC    = 4'd0,
      PH_VERSION  = 4'd1,
      PH_RESERVED = 4'd2,
      PH_SEQ      = 4'd3,
      PH_TIME     = 4'd4,
      PH_OP       = 4'd5,
      PH_TTL      = 4'd6,
      PH_KLEN     = 4'd7,
      PH_KEY      = 4'd8,
      PH_VLEN     = 4'd9,
      PH_VALUE    = 4'd10,
      PH_CRC      = 4'd11
   } phase_type;

   typedef enum logic [1:0] {
      KIND_KEY_BYTE   = 2'd0,
      KIND_VALUE_BYTE = 2'd1,
      KIND_RECORD     = 2'd2,
      KIND_ERROR      = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      STATUS_OK        = 3'd0,
      STATUS_BAD_MAGIC = 3'd1,
      STATUS_BAD_VER   = 3'd2,
      STATUS_CRC_BAD   = 3'd3,
      STATUS_TRUNCATED = 3'd4
   } status_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       stream_end;
   } req_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic [7:0]         payload_byte;
      logic [7:0]         operation;
      logic [63:0]        seq_number;
      logic [63:0]        timestamp_us;
      logic signed [63:0] ttl_ms;
      logic [31:0]        key_length;
      logic [31:0]        value_length;
      logic [2:0]         status;
   } rsp_type;

   typedef struct packed {
      logic [31:0] magic_word;
      logic [15:0] format_version;
   } cfg_type;

   // The second push is only ever used together with the first.
   typedef struct packed {
      logic first;
      logic second;
   } push_type;

   typedef struct packed {
      logic [FifoCountWidth-1:0] level;
   } fifo_status_type;

   function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] data);
      logic [31:0] c;
      c = crc ^ {24'd0, data};
      for (int i = 0; i < 8; i++) begin
         c = (c >> 1) ^ (CrcPoly & {32{c[0]}});
      end
      return c;
   endfunction

   // Byte count of each fixed-size field; the key and value have their own lengths.
   function automatic logic [3:0] field_size(input phase_type phase);
      logic [3:0] size;
      case (phase)
         PH_MAGIC:    size = 4'd4;
         PH_VERSION:  size = 4'd2;
         PH_RESERVED: size = 4'd2;
         PH_SEQ:      size = 4'd8;
         PH_TIME:     size = 4'd8;
         PH_OP:       size = 4'd1;
         PH_TTL:      size = 4'd8;
         PH_KLEN:     size = 4'd4;
         PH_KEY:      size = 4'd0;
         PH_VLEN:     size = 4'd4;
         PH_VALUE:    size = 4'd0;
         PH_CRC:      size = 4'd4;
         default:     size = 4'd1;
      endcase
      return size;
   endfunction

endpackage

// ----- design/lrp_parser.sv -----
module lrp_parser import lrp_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   input  req_type  in_data,
   input  cfg_type  cfg,
   output push_type push,
   output rsp_type  res_first,
   output rsp_type  res_second
);

   phase_type   phase_ff, phase_in;
   logic [31:0] count_ff, count_in;
   logic [31:0] crc_ff, crc_in;
   logic [63:0] shift_ff, shift_in;
   logic [63:0] seq_ff, seq_in;
   logic [63:0] time_ff, time_in;
   logic [63:0] ttl_ff, ttl_in;
   logic [7:0]  op_ff, op_in;
   logic [31:0] klen_ff, klen_in;
   logic [31:0] vlen_ff, vlen_in;
   logic        halted_ff, halted_in;

   logic [7:0]  byte_in;
   logic        end_in;
   logic        active;
   logic        data_phase;
   logic [31:0] count_inc;
   logic [63:0] shift_merged;
   logic [31:0] crc_upd;
   logic        field_done;
   logic        key_done;
   logic        val_done;
   logic        magic_err;
   logic        version_err;
   logic        hdr_err;
   logic        crc_end;
   logic        crc_good;

   // Per-beat datapath shared by the next-state and result logic.
   always_comb begin
      byte_in      = in_data.data_byte;
      end_in       = in_data.stream_end;
      active       = in_valid && !halted_ff;
      data_phase   = phase_ff inside {PH_KEY, PH_VALUE};
      count_inc    = count_ff + 32'd1;
      shift_merged = shift_ff | ({56'd0, byte_in} << {count_ff[2:0], 3'b000});
      crc_upd      = crc32_byte(crc_ff, byte_in);
      field_done   = count_inc >= {28'd0, field_size(phase_ff)};
      key_done     = count_inc >= klen_ff;
      val_done     = count_inc >= vlen_ff;
      magic_err    = (phase_ff == PH_MAGIC) && field_done
                     && (shift_merged[31:0] != cfg.magic_word);
      version_err  = (phase_ff == PH_VERSION) && field_done
                     && (shift_merged[15:0] != cfg.format_version);
      hdr_err      = magic_err || version_err;
      crc_end      = (phase_ff == PH_CRC) && field_done;
      crc_good     = shift_merged[31:0] == ~crc_ff;
   end

   // Next state.
   always_comb begin
      phase_in  = phase_ff;
      count_in  = count_ff;
      crc_in    = crc_ff;
      shift_in  = shift_ff;
      seq_in    = seq_ff;
      time_in   = time_ff;
      ttl_in    = ttl_ff;
      op_in     = op_ff;
      klen_in   = klen_ff;
      vlen_in   = vlen_ff;
      halted_in = halted_ff;

      if (in_valid && halted_ff) begin
         if (end_in) begin
            halted_in = 1'b0;
            phase_in  = PH_MAGIC;
            count_in  = '0;
            shift_in  = '0;
            crc_in    = CrcAllOnes;
         end
      end else if (active) begin
         shift_in = shift_merged;
         count_in = count_inc;
         if (phase_ff inside {PH_SEQ, PH_TIME, PH_OP}) begin
            crc_in = crc_upd;
         end
         case (phase_ff)
            PH_KEY: begin
               crc_in   = crc_upd;
               shift_in = shift_ff;
               if (key_done) begin
                  phase_in = PH_VLEN;
                  count_in = '0;
                  shift_in = '0;
               end
            end
            PH_VALUE: begin
               crc_in   = crc_upd;
               shift_in = shift_ff;
               if (val_done) begin
                  phase_in = PH_CRC;
                  count_in = '0;
                  shift_in = '0;
               end
            end
            PH_MAGIC, PH_VERSION, PH_RESERVED, PH_SEQ, PH_TIME, PH_OP, PH_TTL, PH_KLEN,
            PH_VLEN, PH_CRC: begin
               if (field_done) begin
                  count_in = '0;
                  shift_in = '0;
                  case (phase_ff)
                     PH_MAGIC:    phase_in = PH_VERSION;
                     PH_VERSION:  phase_in = PH_RESERVED;
                     PH_RESERVED: phase_in = PH_SEQ;
                     PH_SEQ: begin
                        seq_in   = shift_merged;
                        phase_in = PH_TIME;
                     end
                     PH_TIME: begin
                        time_in  = shift_merged;
                        phase_in = PH_OP;
                     end
                     PH_OP: begin
                        op_in    = shift_merged[7:0];
                        phase_in = PH_TTL;
                     end
                     PH_TTL: begin
                        ttl_in   = shift_merged;
                        phase_in = PH_KLEN;
                     end
                     PH_KLEN: begin
                        klen_in  = shift_merged[31:0];
                        phase_in = (shift_merged[31:0] != 32'd0) ? PH_KEY : PH_VLEN;
                     end
                     PH_VLEN: begin
                        vlen_in  = shift_merged[31:0];
                        phase_in = (shift_merged[31:0] != 32'd0) ? PH_VALUE : PH_CRC;
                     end
                     default: phase_in = PH_MAGIC;
                  endcase
               end
            end
            default: phase_in = PH_MAGIC;
         endcase

         // A record end, an error, a stream end or an out-of-range phase starts a fresh record.
         if (hdr_err || crc_end || end_in || phase_ff > PH_CRC) begin
            phase_in = PH_MAGIC;
            count_in = '0;
            shift_in = '0;
            crc_in   = CrcAllOnes;
         end
         halted_in = (hdr_err || (crc_end && !crc_good)) && !end_in;
      end
   end

   // Results of the beat.
   always_comb begin
      res_first  = '0;
      res_second = '0;
      push       = '0;

      if (data_phase) begin
         res_first.kind         = (phase_ff == PH_KEY) ? KIND_KEY_BYTE : KIND_VALUE_BYTE;
         res_first.payload_byte = byte_in;
      end else if (crc_end) begin
         res_first.kind            = KIND_RECORD;
         res_first.operation       = op_ff;
         res_first.seq_number      = seq_ff;
         res_first.timestamp_us    = time_ff;
         res_first.ttl_ms          = ttl_ff;
         res_first.key_length      = klen_ff;
         res_first.value_length    = vlen_ff;
         res_first.status          = crc_good ? STATUS_OK : STATUS_CRC_BAD;
      end else if (hdr_err) begin
         res_first.kind   = KIND_ERROR;
         res_first.status = magic_err ? STATUS_BAD_MAGIC : STATUS_BAD_VER;
      end else begin
         res_first.kind   = KIND_ERROR;
         res_first.status = STATUS_TRUNCATED;
      end

      // A stream end inside the key or value reports the byte, then the truncation.
      res_second.kind   = KIND_ERROR;
      res_second.status = STATUS_TRUNCATED;

      push.first  = active && (data_phase || crc_end || hdr_err || end_in);
      push.second = active && data_phase && end_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_MAGIC;
         count_ff  <= '0;
         crc_ff    <= CrcAllOnes;
         shift_ff  <= '0;
         seq_ff    <= '0;
         time_ff   <= '0;
         ttl_ff    <= '0;
         op_ff     <= '0;
         klen_ff   <= '0;
         vlen_ff   <= '0;
         halted_ff <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         count_ff  <= count_in;
         crc_ff    <= crc_in;
         shift_ff  <= shift_in;
         seq_ff    <= seq_in;
         time_ff   <= time_in;
         ttl_ff    <= ttl_in;
         op_ff     <= op_in;
         klen_ff   <= klen_in;
         vlen_ff   <= vlen_in;
         halted_ff <= halted_in;
      end
   end

endmodule

// ----- design/lrp_result_fifo.sv -----
module lrp_result_fifo import lrp_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  push_type        push,
   input  rsp_type         wr_first,
   input  rsp_type         wr_second,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_type         rsp_data,
   output fifo_status_type status
);

   rsp_type                   entry_ff [FifoDepth];
   logic [FifoPtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FifoPtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FifoCountWidth-1:0] level_ff, level_in;
   logic [FifoPtrWidth-1:0]   wr_next;
   logic                      pop;
   logic [FifoCountWidth-1:0] push_count;

   always_comb begin
      wr_next    = wr_ptr_ff + FifoPtrWidth'(1);
      pop        = rsp_valid && !rsp_stall;
      push_count = FifoCountWidth'(push.first) + FifoCountWidth'(push.second);
      wr_ptr_in  = wr_ptr_ff + push_count[FifoPtrWidth-1:0];
      rd_ptr_in  = rd_ptr_ff + FifoPtrWidth'(pop);
      level_in   = level_ff + push_count - FifoCountWidth'(pop);
   end

   assign rsp_valid    = level_ff != '0;
   assign rsp_data     = entry_ff[rd_ptr_ff];
   assign status.level = level_ff;

   always_ff @(posedge clock) begin
      if (push.first) begin
         entry_ff[wr_ptr_ff] <= wr_first;
      end
      if (push.second) begin
         entry_ff[wr_next] <= wr_second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

endmodule

// ----- design/log_record_parser_crc32_core.sv -----
// Channel   Direction  Handshake             Payload
// req_      in         req_valid/req_stall   req_type: data_byte, stream_end
// rsp_      out        rsp_valid/rsp_stall   rsp_type: kind, fields, status
// csr_      in         csr_write_enable      csr_index, csr_write_data
//
// One byte is accepted per cycle while req_stall is low. A byte is held in the input register, is
// parsed from there into the result queue, and each result is offered on rsp_ until it is taken.
// A stream-end byte inside a key or value gives two results, every other byte at most one.
// req_stall comes from the four-entry result queue level and the byte in flight only.
// Reset is synchronous and restores the default magic word and version with the parser idle.
`include "log_record_parser_crc32_core_macros.svh"

module log_record_parser_crc32_core import lrp_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  req_type                  req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output rsp_type                  rsp_data,
   input  logic                     csr_write_enable,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_write_data
);

   cfg_type         cfg_ff, cfg_in;
   logic            in_valid_ff, in_valid_in;
   req_type         in_data_ff, in_data_in;
   logic            accept;
   push_type        push;
   rsp_type         res_first;
   rsp_type         res_second;
   fifo_status_type fifo_status;
   logic [FifoCountWidth:0] committed;

   // Worst-case queue use once the byte in flight has been parsed.
   always_comb begin
      committed = {1'b0, fifo_status.level} + (FifoCountWidth + 1)'(in_valid_ff)
                  + (FifoCountWidth + 1)'(in_valid_ff && in_data_ff.stream_end);
      req_stall = committed > (FifoCountWidth + 1)'(FifoDepth - 2);
      accept    = req_valid && !req_stall;
      in_valid_in = accept;
      in_data_in  = accept ? req_data : in_data_ff;
   end

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_MAGIC_WORD:     cfg_in.magic_word     = csr_write_data[31:0];
            CSR_FORMAT_VERSION: cfg_in.format_version = csr_write_data[15:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      in_data_ff <= in_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff           <= 1'b0;
         cfg_ff.magic_word     <= MagicReset;
         cfg_ff.format_version <= VersionReset;
      end else begin
         in_valid_ff <= in_valid_in;
         cfg_ff      <= cfg_in;
      end
   end

   lrp_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (in_valid_ff),
      .in_data    (in_data_ff),
      .cfg        (cfg_ff),
      .push       (push),
      .res_first  (res_first),
      .res_second (res_second)
   );

   lrp_result_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .wr_first  (res_first),
      .wr_second (res_second),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .status    (fifo_status)
   );

   `LRP_ASSERT_IMPLY(a_level_in_range, clock, reset, 1'b1,
      fifo_status.level <= FifoCountWidth'(FifoDepth), "result queue overflow")
   `LRP_ASSERT_IMPLY(a_second_only_at_end, clock, reset, push.second,
      push.first && in_valid_ff && in_data_ff.stream_end, "second result without stream end")
   `LRP_ASSERT_IMPLY(a_push_needs_beat, clock, reset, push.first, in_valid_ff,
      "result pushed without a byte")
   `LRP_ASSERT_NEXT(a_drain_empties, clock, reset,
      rsp_valid && !rsp_stall && fifo_status.level == FifoCountWidth'(1) && !push.first,
      !rsp_valid, "queue not empty after last beat taken")

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top import lrp_pkg::*; ();

   typedef struct packed {
      logic [31:0] magic;
      logic [15:0] version;
      logic [63:0] seq;
      logic [63:0] stamp;
      logic [7:0]  op;
      logic [63:0] ttl;
      logic [31:0] key_len;
      logic [31:0] value_size;
   } record_type;

   localparam int KeepAll = 32'h7FFF_FFFF;
   // Bytes from the magic through the key length field.
   localparam int HeaderBytes = 37;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   req_type                  req_data = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   rsp_type                  rsp_data;
   logic                     csr_write_enable = 1'b0;
   logic [CsrIndexWidth-1:0] csr_index = CSR_MAGIC_WORD;
   logic [CsrDataWidth-1:0]  csr_write_data = '0;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int stall_hold = 0;
   int mismatches = 0;

   // Parser state as the block should hold it.
   logic [31:0] cfg_magic = MagicReset;
   logic [15:0] cfg_version = VersionReset;
   phase_type   phase = PH_MAGIC;
   logic [31:0] byte_count = '0;
   logic [31:0] crc = CrcAllOnes;
   logic [63:0] shift = '0;
   logic [63:0] seq_hold = '0;
   logic [63:0] stamp_hold = '0;
   logic [63:0] ttl_hold = '0;
   logic [7:0]  op_hold = '0;
   logic [31:0] key_len_hold = '0;
   logic [31:0] value_size_hold = '0;
   logic        halted = 1'b0;

   rsp_type outputs_due[$];

   log_record_parser_crc32_core u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [31:0] crc_step(input logic [31:0] value, input logic [7:0] b);
      logic [31:0] c;
      c = value ^ {24'd0, b};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ 32'hEDB88320) : (c >> 1);
      end
      return c;
   endfunction

   function automatic int unsigned field_bytes(input phase_type p);
      case (p)
         PH_MAGIC, PH_KLEN, PH_VLEN, PH_CRC: return 4;
         PH_VERSION, PH_RESERVED:            return 2;
         PH_SEQ, PH_TIME, PH_TTL:            return 8;
         default:                            return 1;
      endcase
   endfunction

   function automatic rsp_type make_output(input kind_type kind, input logic [7:0] payload,
                                           input status_type status, input bit full);
      rsp_type r;
      r = '0;
      r.kind = kind;
      r.payload_byte = payload;
      r.status = status;
      if (full) begin
         r.operation = op_hold;
         r.seq_number = seq_hold;
         r.timestamp_us = stamp_hold;
         r.ttl_ms = ttl_hold;
         r.key_length = key_len_hold;
         r.value_length = value_size_hold;
      end
      return r;
   endfunction

   task automatic next_field(input phase_type p);
      phase = p;
      byte_count = '0;
      shift = '0;
   endtask

   task automatic restart_record();
      next_field(PH_MAGIC);
      crc = CrcAllOnes;
   endtask

   task automatic parse_byte(input req_type beat);
      logic [7:0] b;
      logic       fin;
      status_type err;
      bit         done;
      b = beat.data_byte;
      fin = beat.stream_end;
      err = STATUS_OK;
      done = 1'b0;
      if (halted) begin
         if (fin) begin
            halted = 1'b0;
            restart_record();
         end
         return;
      end
      if (phase inside {PH_KEY, PH_VALUE}) begin
         crc = crc_step(crc, b);
         outputs_due.insert(outputs_due.size(),
                            make_output(phase == PH_KEY ? KIND_KEY_BYTE : KIND_VALUE_BYTE,
                                        b, STATUS_OK, 1'b0));
         byte_count++;
         if (phase == PH_KEY && byte_count >= key_len_hold) next_field(PH_VLEN);
         else if (phase == PH_VALUE && byte_count >= value_size_hold) next_field(PH_CRC);
      end else begin
         if (phase inside {PH_SEQ, PH_TIME, PH_OP}) crc = crc_step(crc, b);
         shift = shift | (64'(b) << (8 * byte_count[2:0]));
         byte_count++;
         if (byte_count >= field_bytes(phase)) begin
            case (phase)
               PH_MAGIC: begin
                  if (shift[31:0] != cfg_magic) err = STATUS_BAD_MAGIC;
                  else next_field(PH_VERSION);
               end
               PH_VERSION: begin
                  if (shift[15:0] != cfg_version) err = STATUS_BAD_VER;
                  else next_field(PH_RESERVED);
               end
               PH_RESERVED: next_field(PH_SEQ);
               PH_SEQ: begin
                  seq_hold = shift;
                  next_field(PH_TIME);
               end
               PH_TIME: begin
                  stamp_hold = shift;
                  next_field(PH_OP);
               end
               PH_OP: begin
                  op_hold = shift[7:0];
                  next_field(PH_TTL);
               end
               PH_TTL: begin
                  ttl_hold = shift;
                  next_field(PH_KLEN);
               end
               PH_KLEN: begin
                  key_len_hold = shift[31:0];
                  next_field(key_len_hold != 0 ? PH_KEY : PH_VLEN);
               end
               PH_VLEN: begin
                  value_size_hold = shift[31:0];
                  next_field(value_size_hold != 0 ? PH_VALUE : PH_CRC);
               end
               default: begin
                  if (shift[31:0] == ~crc) begin
                     outputs_due.insert(outputs_due.size(),
                                        make_output(KIND_RECORD, 8'd0, STATUS_OK, 1'b1));
                     done = 1'b1;
                  end else begin
                     outputs_due.insert(outputs_due.size(),
                                        make_output(KIND_RECORD, 8'd0, STATUS_CRC_BAD, 1'b1));
                     err = STATUS_CRC_BAD;
                  end
                  restart_record();
               end
            endcase
         end
      end
      // A checksum mismatch is reported by the record beat itself.
      if (err != STATUS_OK) begin
         if (err != STATUS_CRC_BAD)
            outputs_due.insert(outputs_due.size(), make_output(KIND_ERROR, 8'd0, err, 1'b0));
         restart_record();
         halted = !fin;
      end else if (fin) begin
         if (!done)
            outputs_due.insert(outputs_due.size(),
                               make_output(KIND_ERROR, 8'd0, STATUS_TRUNCATED, 1'b0));
         restart_record();
      end
   endtask

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      mismatches++;
   endtask

   task automatic compare_field(input string name, input logic [63:0] got,
                                input logic [63:0] want);
      if (got !== want) report_mismatch($sformatf("%s got %h expected %h", name, got, want));
   endtask

   task automatic check_result(input rsp_type got);
      rsp_type want;
      if (outputs_due.size() == 0) begin
         report_mismatch($sformatf("result of kind %0d with nothing expected", got.kind));
         return;
      end
      want = outputs_due.pop_front();
      compare_field("kind", 64'(got.kind), 64'(want.kind));
      compare_field("payload_byte", 64'(got.payload_byte), 64'(want.payload_byte));
      compare_field("operation", 64'(got.operation), 64'(want.operation));
      compare_field("seq_number", got.seq_number, want.seq_number);
      compare_field("timestamp_us", got.timestamp_us, want.timestamp_us);
      compare_field("ttl_ms", got.ttl_ms, want.ttl_ms);
      compare_field("key_length", 64'(got.key_length), 64'(want.key_length));
      compare_field("value_length", 64'(got.value_length), 64'(want.value_length));
      compare_field("status", 64'(got.status), 64'(want.status));
   endtask

   // Result side: the handshake is judged on the values that held before the edge.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) check_result(rsp_data);
      if (stall_hold > 0) begin
         rsp_stall <= 1'b1;
         stall_hold = stall_hold - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // Returns in the time step of the accepting edge, with valid still high.
   task automatic send_beat(input req_type beat);
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_data <= beat;
      do @(posedge clock); while (req_stall);
      parse_byte(beat);
   endtask

   task automatic send_stream(ref req_type stream[$]);
      foreach (stream[i]) send_beat(stream[i]);
      req_valid <= 1'b0;
   endtask

   task automatic set_idling(input int sender_pct, input int receiver_pct);
      @(negedge clock);
      send_idle_pct = sender_pct;
      recv_idle_pct = receiver_pct;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      while (outputs_due.size() != 0) @(posedge clock);
   endtask

   task automatic configure(input logic [31:0] magic, input logic [15:0] version);
      wait_drained();
      // A beat that gives no result may still sit in the pipeline.
      repeat (8) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= CSR_MAGIC_WORD;
      csr_write_data <= magic;
      @(posedge clock);
      cfg_magic = magic;
      csr_index <= CSR_FORMAT_VERSION;
      csr_write_data <= {16'($urandom), version};
      @(posedge clock);
      cfg_version = version;
      csr_write_enable <= 1'b0;
   endtask

   function automatic void push_le(ref logic [7:0] bytes[$], ref logic [31:0] sum,
                                   input logic [63:0] value, input int count, input bit in_crc);
      for (int i = 0; i < count; i++) begin
         bytes.insert(bytes.size(), value[8*i +: 8]);
         if (in_crc) sum = crc_step(sum, value[8*i +: 8]);
      end
   endfunction

   function automatic record_type random_record(input int max_len);
      record_type r;
      r.magic = cfg_magic;
      r.version = cfg_version;
      r.seq = {$urandom, $urandom};
      r.stamp = {$urandom, $urandom};
      r.op = 8'($urandom);
      r.ttl = {$urandom, $urandom};
      r.key_len = $urandom_range(max_len);
      r.value_size = $urandom_range(max_len);
      return r;
   endfunction

   // Appends a record cut to at most keep bytes; last marks its final beat as the stream end.
   task automatic append_record(ref req_type stream[$], input record_type rec, input int keep,
                                input bit bad_crc, input bit last);
      logic [7:0]  bytes[$];
      logic [31:0] sum;
      logic [31:0] check_word;
      req_type     beat;
      sum = CrcAllOnes;
      push_le(bytes, sum, 64'(rec.magic), 4, 1'b0);
      push_le(bytes, sum, 64'(rec.version), 2, 1'b0);
      push_le(bytes, sum, 64'($urandom), 2, 1'b0);
      push_le(bytes, sum, rec.seq, 8, 1'b1);
      push_le(bytes, sum, rec.stamp, 8, 1'b1);
      push_le(bytes, sum, 64'(rec.op), 1, 1'b1);
      push_le(bytes, sum, rec.ttl, 8, 1'b0);
      push_le(bytes, sum, 64'(rec.key_len), 4, 1'b0);
      for (longint i = 0; i < rec.key_len && bytes.size() < keep; i++)
         push_le(bytes, sum, 64'($urandom_range(255)), 1, 1'b1);
      push_le(bytes, sum, 64'(rec.value_size), 4, 1'b0);
      for (longint i = 0; i < rec.value_size && bytes.size() < keep; i++)
         push_le(bytes, sum, 64'($urandom_range(255)), 1, 1'b1);
      check_word = ~sum;
      if (bad_crc) check_word = check_word ^ (32'h1 << $urandom_range(31));
      push_le(bytes, sum, 64'(check_word), 4, 1'b0);
      while (bytes.size() > keep) void'(bytes.pop_back());
      foreach (bytes[i]) begin
         beat.data_byte = bytes[i];
         beat.stream_end = 1'b0;
         stream.insert(stream.size(), beat);
      end
      if (last && stream.size() > 0) stream[stream.size()-1].stream_end = 1'b1;
   endtask

   task automatic append_noise(ref req_type stream[$], input int count);
      req_type beat;
      for (int i = 0; i < count; i++) begin
         beat.data_byte = 8'($urandom);
         beat.stream_end = (i == count - 1);
         stream.insert(stream.size(), beat);
      end
   endtask

   task automatic test_good_records();
      req_type stream[$];
      record_type rec;
      rec = random_record(0);
      rec.seq = '1;
      rec.stamp = '0;
      rec.ttl = 64'h8000_0000_0000_0000;
      rec.op = 8'hFF;
      append_record(stream, rec, KeepAll, 1'b0, 1'b1);
      rec = random_record(0);
      rec.seq = '0;
      rec.stamp = '1;
      rec.ttl = 64'h7FFF_FFFF_FFFF_FFFF;
      rec.op = 8'h00;
      rec.key_len = 3;
      rec.value_size = 2;
      append_record(stream, rec, KeepAll, 1'b0, 1'b0);
      rec = random_record(4);
      rec.ttl = '1;
      rec.key_len = 1;
      rec.value_size = 0;
      append_record(stream, rec, KeepAll, 1'b0, 1'b1);
      send_stream(stream);
   endtask

   task automatic test_header_errors();
      req_type stream[$];
      record_type rec;
      rec = random_record(2);
      rec.magic = rec.magic ^ 32'h8000_0000;
      append_record(stream, rec, 9, 1'b0, 1'b0);
      append_noise(stream, 3);
      // Errors that land on the stream end beat leave the parser ready at once.
      rec = random_record(2);
      rec.version = rec.version ^ 16'h0001;
      append_record(stream, rec, 6, 1'b0, 1'b1);
      rec = random_record(2);
      rec.magic = rec.magic ^ 32'h0000_0001;
      append_record(stream, rec, 4, 1'b0, 1'b1);
      append_record(stream, random_record(3), KeepAll, 1'b0, 1'b1);
      send_stream(stream);
   endtask

   task automatic test_checksum_errors();
      req_type stream[$];
      append_record(stream, random_record(4), KeepAll, 1'b1, 1'b0);
      append_noise(stream, 2);
      append_record(stream, random_record(4), KeepAll, 1'b1, 1'b1);
      append_record(stream, random_record(4), KeepAll, 1'b0, 1'b1);
      send_stream(stream);
   endtask

   task automatic test_truncation();
      req_type stream[$];
      record_type rec;
      append_noise(stream, 1);
      append_record(stream, random_record(3), 13, 1'b0, 1'b1);
      rec = random_record(0);
      rec.key_len = 32'hFFFF_FFFF;
      append_record(stream, rec, HeaderBytes + 3, 1'b0, 1'b1);
      rec = random_record(0);
      rec.key_len = 2;
      rec.value_size = 32'h8000_0000;
      append_record(stream, rec, HeaderBytes + 2 + 4 + 5, 1'b0, 1'b1);
      rec = random_record(0);
      rec.key_len = 0;
      rec.value_size = 0;
      append_record(stream, rec, HeaderBytes + 4 + 3, 1'b0, 1'b1);
      send_stream(stream);
   endtask

   task automatic test_config_extremes();
      req_type stream[$];
      record_type rec;
      configure(32'h0000_0000, 16'h0000);
      append_record(stream, random_record(3), KeepAll, 1'b0, 1'b1);
      rec = random_record(3);
      rec.version = 16'h8000;
      append_record(stream, rec, KeepAll, 1'b0, 1'b1);
      send_stream(stream);
      configure(32'hFFFF_FFFF, 16'hFFFF);
      stream.delete();
      append_record(stream, random_record(3), KeepAll, 1'b0, 1'b1);
      rec = random_record(3);
      rec.magic = 32'h7FFF_FFFF;
      append_record(stream, rec, 5, 1'b0, 1'b1);
      send_stream(stream);
      configure(MagicReset, VersionReset);
   endtask

   task automatic test_backpressure();
      req_type stream[$];
      record_type rec;
      for (int i = 0; i < 6; i++) begin
         rec = random_record(0);
         rec.key_len = 10;
         rec.value_size = 10;
         append_record(stream, rec, KeepAll, 1'b0, i == 5);
      end
      @(negedge clock);
      stall_hold = 300;
      @(posedge clock);
      send_stream(stream);
   endtask

   task automatic test_sender_pause();
      req_type stream[$];
      req_type head[$];
      req_type tail[$];
      record_type rec;
      rec = random_record(0);
      rec.key_len = 8;
      rec.value_size = 4;
      append_record(stream, rec, KeepAll, 1'b0, 1'b1);
      head = stream[0:HeaderBytes + 3];
      tail = stream[HeaderBytes + 4:$];
      send_stream(head);
      wait_drained();
      send_stream(tail);
   endtask

   task automatic test_random_traffic(input int beats_wanted);
      req_type stream[$];
      record_type rec;
      int      pick;
      bit      last;
      while (stream.size() < beats_wanted) begin
         pick = $urandom_range(99);
         last = ($urandom_range(3) == 0);
         rec = random_record($urandom_range(9) == 0 ? 24 : 6);
         if (pick < 70) begin
            append_record(stream, rec, KeepAll, 1'b0, last);
         end else if (pick < 76) begin
            rec.magic = rec.magic ^ (32'h1 << $urandom_range(31));
            if (last) begin
               append_record(stream, rec, 4, 1'b0, 1'b1);
            end else begin
               append_record(stream, rec, $urandom_range(4, 12), 1'b0, 1'b0);
               append_noise(stream, $urandom_range(1, 5));
            end
         end else if (pick < 82) begin
            rec.version = rec.version ^ (16'h1 << $urandom_range(15));
            if (last) begin
               append_record(stream, rec, 6, 1'b0, 1'b1);
            end else begin
               append_record(stream, rec, $urandom_range(6, 14), 1'b0, 1'b0);
               append_noise(stream, $urandom_range(1, 5));
            end
         end else if (pick < 88) begin
            append_record(stream, rec, KeepAll, 1'b1, last);
            if (!last) append_noise(stream, $urandom_range(1, 5));
         end else if (pick < 95) begin
            if ($urandom_range(1) == 1) rec.key_len = $urandom;
            if ($urandom_range(1) == 1) rec.value_size = $urandom;
            append_record(stream, rec, $urandom_range(1, 60), 1'b0, 1'b1);
         end else begin
            append_noise(stream, $urandom_range(1, 8));
         end
      end
      send_stream(stream);
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      set_idling(23, 80);
      test_good_records();
      test_header_errors();
      test_checksum_errors();
      test_truncation();
      test_config_extremes();
      test_backpressure();
      test_sender_pause();
      configure($urandom, 16'($urandom));
      test_random_traffic(270);
      set_idling(80, 23);
      configure(MagicReset, VersionReset);
      test_random_traffic(270);
      set_idling(0, 0);
      configure($urandom, 16'($urandom));
      test_random_traffic(270);
      wait_drained();
      repeat (10) @(posedge clock);
      if (mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("timeout with %0d results outstanding", outputs_due.size());
      $display("status: fail");
      $finish;
   end

endmodule
